>>> rtl/core/rmsi_pkg.sv
// shared constants and types for the running median sorted-insert block
// no dependencies
package rmsi_pkg;

    localparam int CAPACITY    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int MED_BITS    = SAMPLE_BITS + 1;
    localparam int COUNT_BITS  = 7;
    localparam int CNT_BITS    = $clog2(CAPACITY + 1);
    localparam int IDX_BITS    = $clog2(CAPACITY);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [MED_BITS-1:0]    t_med;
    typedef logic [CNT_BITS-1:0]           t_cnt;
    typedef logic [IDX_BITS-1:0]           t_idx;

    typedef struct packed {
        logic load;
        logic occ;
        logic tail;
    } t_cell_ctl;

endpackage

>>> rtl/core/rmsi_in_if.sv
// input channel: sample and start flag with valid/ready
// depends on rmsi_pkg
interface rmsi_in_if;
    import rmsi_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    start_new;

    modport source (output valid, output sample, output start_new, input ready);
    modport sink   (input valid, input sample, input start_new, output ready);
endinterface

>>> rtl/core/rmsi_out_if.sv
// output channel: doubled median, count and overflow with valid/ready
// depends on rmsi_pkg
interface rmsi_out_if;
    import rmsi_pkg::*;

    logic                  valid;
    logic                  ready;
    t_med                  median_x2;
    logic [COUNT_BITS-1:0] count;
    logic                  overflow;

    modport source (output valid, output median_x2, output count, output overflow,
                    input ready);
    modport sink   (input valid, input median_x2, input count, input overflow,
                    output ready);
endinterface

>>> rtl/core/rmsi_cell.sv
// one cell of the sorted insertion chain: holds one stored sample
// depends on rmsi_pkg
module rmsi_cell (
    input  logic                i_clk,
    input  rmsi_pkg::t_cell_ctl i_ctl,
    input  rmsi_pkg::t_sample   i_new,
    input  rmsi_pkg::t_sample   i_prev_val,
    input  logic                i_prev_gt,
    output rmsi_pkg::t_sample   o_val,
    output logic                o_gt
);
    import rmsi_pkg::*;

    t_sample r_val;
    t_sample n_val;

    assign o_gt  = i_ctl.occ && (r_val > i_new);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.load) begin
            if (i_prev_gt) begin
                n_val = i_prev_val;
            end else if (o_gt || i_ctl.tail) begin
                n_val = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end
endmodule

>>> rtl/core/running_median_sorted_insert_top.sv
// Running median by sorted insertion. In the accept cycle of a sample the
// cell chain shifts every stored value greater than the sample one place up
// and drops the sample into the gap; once it is stored, the two middle cells
// are picked out of the chain and summed into the doubled median, which is
// loaded into the output register as soon as that register is free. A new
// sample is taken as soon as that output load has happened and not before,
// so a stalled sink also holds the input. start_new empties the store before
// the sample goes in; with the store full and no start flag the sample is
// dropped and overflow is reported along with the unchanged median.
// depends on rmsi_pkg, rmsi_in_if, rmsi_out_if, rmsi_cell
module running_median_sorted_insert_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmsi_in_if.sink    i_in,
    rmsi_out_if.source o_out
);
    import rmsi_pkg::*;

    t_cnt      r_cnt;
    logic      r_pend;
    logic      r_drop;
    logic      r_ovalid;
    t_med      r_med;
    t_cnt      r_ocnt;
    logic      r_ovf;

    logic      w_acc;
    t_cnt      w_cnt_eff;
    logic      w_full;
    logic      w_load_out;
    t_sample   w_val [CAPACITY];
    logic      w_gt  [CAPACITY];
    t_idx      w_hi;
    t_idx      w_lo;
    t_sample   w_hi_val;
    t_sample   w_lo_val;
    t_med      w_med;
    t_cnt      w_half;

    assign i_in.ready = !r_pend;
    assign w_acc      = i_in.valid && !r_pend;
    assign w_cnt_eff  = i_in.start_new ? '0 : r_cnt;
    assign w_full     = (w_cnt_eff == CNT_BITS'(CAPACITY));

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl.load = w_acc && !w_full;
        assign w_ctl.occ  = CNT_BITS'(g) < w_cnt_eff;
        assign w_ctl.tail = CNT_BITS'(g) == w_cnt_eff;
        if (g == 0) begin : g_first
            rmsi_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_new      (i_in.sample),
                .i_prev_val (i_in.sample),
                .i_prev_gt  (1'b0),
                .o_val      (w_val[g]),
                .o_gt       (w_gt[g])
            );
        end else begin : g_rest
            rmsi_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_new      (i_in.sample),
                .i_prev_val (w_val[g-1]),
                .i_prev_gt  (w_gt[g-1]),
                .o_val      (w_val[g]),
                .o_gt       (w_gt[g])
            );
        end
    end

    // middle pair selection
    assign w_half = r_cnt >> 1;
    assign w_hi   = w_half[IDX_BITS-1:0];
    assign w_lo   = w_hi - IDX_BITS'(!r_cnt[0]);

    always_comb begin
        w_hi_val = '0;
        w_lo_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (IDX_BITS'(i) == w_hi) begin
                w_hi_val = w_hi_val | w_val[i];
            end
            if (IDX_BITS'(i) == w_lo) begin
                w_lo_val = w_lo_val | w_val[i];
            end
        end
    end

    assign w_med      = {w_lo_val[SAMPLE_BITS-1], w_lo_val}
                      + {w_hi_val[SAMPLE_BITS-1], w_hi_val};
    assign w_load_out = r_pend && (!r_ovalid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_cnt  <= w_full ? w_cnt_eff : w_cnt_eff + CNT_BITS'(1);
                r_drop <= w_full;
                r_pend <= 1'b1;
            end else if (w_load_out) begin
                r_pend <= 1'b0;
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (w_load_out) begin
            r_med  <= w_med;
            r_ocnt <= r_cnt;
            r_ovf  <= r_drop;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.median_x2 = r_med;
    assign o_out.count     = COUNT_BITS'(r_ocnt);
    assign o_out.overflow  = r_ovf;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(CAPACITY))
        else $error("held count above capacity");

    a_acc_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_pend)
        else $error("accepted transfer not pending");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ovf) |-> (r_ocnt == CNT_BITS'(CAPACITY)))
        else $error("overflow reported with store not full");

    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_ocnt != '0))
        else $error("result with empty store");
`endif
endmodule
